FILE: src/mlfq_scheduler_top_assert.svh
// Assertion macros for the feedback queue scheduler.
// Used by mlfq_scheduler_top; relies on clk_i and rst_ni in the including scope.
`ifndef MLFQ_SCHEDULER_TOP_ASSERT_SVH
`define MLFQ_SCHEDULER_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MLFQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked while reset is held.
`define MLFQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/mlfq_pkg.sv
// Types, constants and helpers for the feedback queue scheduler.
// No dependencies.
package mlfq_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int NUM_LEVELS = 5;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int HEAD_W     = SLOT_W + 1;
  localparam int LVL_W      = 3;
  localparam int CNT_W      = 12;
  localparam int STAT_W     = 32;
  localparam int QADDR_W    = $clog2(NUM_LEVELS * NUM_SLOTS);
  localparam int TS_W       = 60;
  localparam int AL_W       = 48;
  localparam int FLD_W      = 12;
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEVELS - 1);
  localparam logic [LVL_W-1:0] LAST_FLD = 3'd4;
  localparam logic [TS_W-1:0] TS_RESET = 60'd4504149450301441;
  localparam logic [AL_W-1:0] AL_RESET = 48'd2062087741470;

  typedef enum logic [2:0] {
    OP_ADMIT, OP_TICK, OP_PICK, OP_YIELD, OP_SLEEP, OP_WAKE, OP_EXIT, OP_QUERY
  } op_e;

  typedef enum logic [1:0] {ST_FREE, ST_SLEEP, ST_READY, ST_RUN} slot_st_e;

  typedef enum logic [1:0] {RS_OK, RS_NONE, RS_FULL, RS_BAD} res_e;

  typedef enum logic [0:0] {CFG_TIME_SLICES, CFG_AGE_LIMITS} cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EXEC, S_TICK, S_HQ, S_HS, S_HE, S_SWITCH, S_FIN
  } state_e;

  typedef enum logic [1:0] {HC_AGE, HC_PICK, HC_YIELD} hctx_e;

  typedef struct packed {
    slot_st_e                         st;
    logic [LVL_W-1:0]                 lvl;
    logic [CNT_W-1:0]                 slice;
    logic [CNT_W-1:0]                 waitc;
    logic [STAT_W-1:0]                runs;
    logic [STAT_W-1:0]                ticks;
    logic [NUM_LEVELS-1:0][STAT_W-1:0] plt;
  } row_t;

  function automatic logic [CNT_W-1:0] inc12(input logic [CNT_W-1:0] v);
    return (v != '1) ? v + CNT_W'(1) : v;
  endfunction

  function automatic logic [STAT_W-1:0] inc32(input logic [STAT_W-1:0] v);
    return (v != '1) ? v + STAT_W'(1) : v;
  endfunction

  function automatic logic [FLD_W-1:0] slice_limit(input logic [TS_W-1:0] ts,
                                                   input logic [LVL_W-1:0] l);
    logic [LVL_W-1:0] i;
    i = (l < LAST_FLD) ? l : LAST_FLD;
    return ts[FLD_W*i +: FLD_W];
  endfunction

  function automatic logic [FLD_W-1:0] age_limit(input logic [AL_W-1:0] al,
                                                 input logic [LVL_W-1:0] l);
    logic [LVL_W-1:0] i;
    i = (l < LAST_FLD) ? l - LVL_W'(1) : LAST_FLD - LVL_W'(1);
    return al[FLD_W*i +: FLD_W];
  endfunction

endpackage

FILE: src/mlfq_scheduler_top.sv
// Five-level feedback queue scheduler: sequencer, slot table memory and queue memory.
// Depends on mlfq_pkg and mlfq_scheduler_top_assert.svh.
//
// One item is one scheduler operation and gives exactly one result item. Items are
// handled one at a time by a sequencer around two single-port-read memories with
// registered read data: a 64-row slot table (state, level, slice and wait counts,
// run statistics) and a 320-entry queue store holding five circular queues. Queue
// head and tail pointers live in flops. Admit, wake and query read the slot's row;
// admit and wake then write it back and queue the slot. Sleep, exit and yield work
// on the running slot and end with an error when no slot runs. Pick ends with an
// error when a slot already runs; else it scans the levels in order for a ready
// queue head. Yield switches on slice expiry and otherwise scans the higher levels
// for a ready head. Tick sweeps the slot table, one row per cycle with read and
// write-back overlapped, then examines the queue heads for aging. An item whose
// result finds the output register still occupied waits until it is free.
// A new item is taken once the previous one is finished, even while its result still
// waits on the output register. Reset leaves no slot in use; rows never written
// read as free through a per-row valid bit, so no clearing pass is needed.
// Configuration writes are always accepted and take effect at once.
module mlfq_scheduler_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [0:0]                 cfg_index_i,
  input  logic [mlfq_pkg::TS_W-1:0]  cfg_data_i,
  // operation items
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 op_i,
  input  logic [5:0]                 slot_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [5:0]                 chosen_slot_o,
  output logic                       switched_o,
  output logic [2:0]                 level_o,
  output logic [31:0]                run_count_o,
  output logic [31:0]                run_time_o,
  output logic [31:0]                level0_ticks_o,
  output logic [31:0]                level1_ticks_o,
  output logic [31:0]                level2_ticks_o,
  output logic [31:0]                level3_ticks_o,
  output logic [31:0]                level4_ticks_o
);
  import mlfq_pkg::*;

  // configuration registers
  logic [TS_W-1:0] ts_q;
  logic [AL_W-1:0] al_q;

  // sequencer state
  state_e             state_q, state_d;
  op_e                op_q;
  logic [SLOT_W-1:0]  slot_q;      // slot field of the item
  logic [SLOT_W-1:0]  cur_s_q;     // slot whose row is being read
  logic [SLOT_W-1:0]  res_slot_q;  // slot reported in the result
  logic [LVL_W-1:0]   lvl_q;       // queue level under examination
  logic [HEAD_W-1:0]  cnt_q;       // tick sweep position
  hctx_e              ctx_q;       // which operation runs the head check
  row_t               cur_row_q;
  res_e               res_st_q;
  logic               res_sw_q;
  logic [LVL_W-1:0]   res_lvl_q;
  logic               run_valid_q;
  logic [SLOT_W-1:0]  run_slot_q;

  // queue pointers; head bit SLOT_W set means empty
  logic [NUM_LEVELS-1:0][HEAD_W-1:0] heads_q;
  logic [NUM_LEVELS-1:0][SLOT_W-1:0] tails_q;

  // slot table memory, valid bit per row
  row_t                  smem [NUM_SLOTS];
  row_t                  smem_rd_q;
  logic                  s_rvalid_q;
  logic [NUM_SLOTS-1:0]  valid_q;
  logic                  s_re, s_we;
  logic [SLOT_W-1:0]     s_raddr, s_waddr;
  row_t                  s_wdata;
  row_t                  row_rd;

  // queue memory
  logic [SLOT_W-1:0]     qmem [NUM_LEVELS*NUM_SLOTS];
  logic [SLOT_W-1:0]     qmem_rd_q;
  logic                  q_re, q_we;
  logic [QADDR_W-1:0]    q_raddr, q_waddr;
  logic [SLOT_W-1:0]     q_widx;

  // push / pop control
  logic                  push_en, push_ok, pop_en;
  logic [LVL_W-1:0]      push_lvl;
  logic [SLOT_W-1:0]     push_slot;
  logic [HEAD_W-1:0]     push_hd;
  logic [SLOT_W-1:0]     push_tl;

  // decisions
  logic                  in_acc, out_load;
  logic                  hd_ready, age_hit, slice_out, adv_last, q_empty;
  logic                  fail_bad;
  row_t                  tick_row;
  logic                  tick_we;
  logic [LVL_W-1:0]      yield_lvl;

  assign in_acc   = in_valid_i & in_ready_o;
  assign out_load = (state_q == S_FIN) && (!out_valid_o || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  assign row_rd = s_rvalid_q ? smem_rd_q : '0;

  // ---------------------------------------------------------------- decisions
  always_comb begin
    q_empty   = heads_q[lvl_q][SLOT_W];
    hd_ready  = (row_rd.st == ST_READY);
    age_hit   = hd_ready && (row_rd.waitc >= age_limit(al_q, lvl_q));
    slice_out = (row_rd.slice >= slice_limit(ts_q, row_rd.lvl));
    yield_lvl = (row_rd.lvl < LAST_LVL) ? row_rd.lvl + LVL_W'(1) : row_rd.lvl;
    case (ctx_q)
      HC_AGE:   adv_last = (lvl_q == LAST_LVL);
      HC_PICK:  adv_last = (lvl_q == LAST_LVL);
      HC_YIELD: adv_last = (lvl_q + LVL_W'(1) == cur_row_q.lvl);
      default:  adv_last = 1'b1;
    endcase
    // tick update of the row read in the previous cycle
    tick_row = row_rd;
    tick_we  = 1'b0;
    if (row_rd.st == ST_READY) begin
      tick_row.waitc = inc12(row_rd.waitc);
      tick_we        = 1'b1;
    end else if (row_rd.st == ST_RUN) begin
      tick_row.slice            = inc12(row_rd.slice);
      tick_row.ticks            = inc32(row_rd.ticks);
      tick_row.plt[row_rd.lvl]  = inc32(row_rd.plt[row_rd.lvl]);
      tick_we                   = 1'b1;
    end
    fail_bad = (op_q == OP_ADMIT && row_rd.st != ST_FREE) ||
               (op_q == OP_WAKE  && row_rd.st != ST_SLEEP) ||
               (op_q == OP_QUERY && row_rd.st == ST_FREE);
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = (op_e'(op_i) == OP_TICK) ? S_TICK : S_READ;
      end
      S_READ: begin
        case (op_q)
          OP_PICK:                     state_d = run_valid_q ? S_FIN : S_HQ;
          OP_YIELD, OP_SLEEP, OP_EXIT: state_d = run_valid_q ? S_EXEC : S_FIN;
          OP_TICK:                     state_d = S_FIN;
          default:                     state_d = S_EXEC;
        endcase
      end
      S_EXEC: begin
        if (op_q == OP_YIELD && !slice_out && row_rd.lvl != '0) state_d = S_HQ;
        else if (op_q == OP_YIELD && slice_out)                 state_d = S_SWITCH;
        else                                                    state_d = S_FIN;
      end
      S_TICK: begin
        if (cnt_q == HEAD_W'(NUM_SLOTS)) state_d = S_HQ;
      end
      S_HQ: begin
        if (!q_empty)      state_d = S_HS;
        else if (adv_last) state_d = S_FIN;
      end
      S_HS: state_d = S_HE;
      S_HE: begin
        case (ctx_q)
          HC_AGE:   state_d = (age_hit || !adv_last) ? S_HQ : S_FIN;
          HC_PICK:  state_d = (hd_ready || adv_last) ? S_FIN : S_HQ;
          HC_YIELD: state_d = hd_ready ? S_SWITCH : (adv_last ? S_FIN : S_HQ);
          default:  state_d = S_FIN;
        endcase
      end
      S_SWITCH: state_d = S_FIN;
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory and queue control
  always_comb begin
    s_re      = 1'b0;
    s_raddr   = slot_q;
    s_we      = 1'b0;
    s_waddr   = cur_s_q;
    s_wdata   = row_rd;
    q_re      = 1'b0;
    q_raddr   = QADDR_W'({lvl_q, heads_q[lvl_q][SLOT_W-1:0]});
    push_en   = 1'b0;
    push_lvl  = '0;
    push_slot = cur_s_q;
    pop_en    = 1'b0;
    case (state_q)
      S_READ: begin
        if (op_q == OP_YIELD || op_q == OP_SLEEP || op_q == OP_EXIT) begin
          s_re    = run_valid_q;
          s_raddr = run_slot_q;
        end else if (op_q != OP_PICK && op_q != OP_TICK) begin
          s_re    = 1'b1;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_ADMIT: begin
            s_we     = !fail_bad;
            s_wdata  = '0;
            s_wdata.st = ST_READY;
            push_en  = !fail_bad;
          end
          OP_WAKE: begin
            s_we          = !fail_bad;
            s_wdata.st    = ST_READY;
            s_wdata.waitc = '0;
            s_wdata.slice = '0;
            push_en       = !fail_bad;
            push_lvl      = row_rd.lvl;
          end
          OP_SLEEP: begin
            s_we       = 1'b1;
            s_wdata.st = ST_SLEEP;
          end
          OP_EXIT: begin
            s_we       = 1'b1;
            s_wdata.st = ST_FREE;
          end
          default: ;
        endcase
      end
      S_TICK: begin
        s_re    = (cnt_q < HEAD_W'(NUM_SLOTS));
        s_raddr = cnt_q[SLOT_W-1:0];
        s_we    = (cnt_q != '0) && tick_we;
        s_waddr = SLOT_W'(cnt_q - HEAD_W'(1));
        s_wdata = tick_row;
      end
      S_HQ: q_re = !q_empty;
      S_HS: begin
        s_re    = 1'b1;
        s_raddr = qmem_rd_q;
      end
      S_HE: begin
        case (ctx_q)
          HC_AGE: begin
            if (age_hit) begin
              pop_en        = 1'b1;
              s_we          = 1'b1;
              s_wdata.lvl   = lvl_q - LVL_W'(1);
              s_wdata.waitc = '0;
              s_wdata.slice = '0;
              push_en       = 1'b1;
              push_lvl      = lvl_q - LVL_W'(1);
            end
          end
          HC_PICK: begin
            if (hd_ready) begin
              pop_en       = 1'b1;
              s_we         = 1'b1;
              s_wdata.st   = ST_RUN;
              s_wdata.runs = inc32(row_rd.runs);
            end
          end
          default: ;
        endcase
      end
      S_SWITCH: begin
        s_we          = 1'b1;
        s_waddr       = run_slot_q;
        s_wdata       = cur_row_q;
        s_wdata.st    = ST_READY;
        s_wdata.lvl   = res_lvl_q;
        s_wdata.waitc = '0;
        s_wdata.slice = '0;
        push_en       = 1'b1;
        push_lvl      = res_lvl_q;
        push_slot     = run_slot_q;
      end
      default: ;
    endcase
  end

  // push: full when the queue already holds NUM_SLOTS entries
  always_comb begin
    push_hd = heads_q[push_lvl];
    push_tl = tails_q[push_lvl];
    push_ok = push_hd[SLOT_W] || ((push_tl - push_hd[SLOT_W-1:0]) != SLOT_W'(NUM_SLOTS - 1));
    q_we    = push_en && push_ok;
    q_widx  = push_hd[SLOT_W] ? '0 : push_tl + SLOT_W'(1);
    q_waddr = QADDR_W'({push_lvl, q_widx});
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    if (s_re) smem_rd_q <= smem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) qmem[q_waddr] <= push_slot;
    if (q_re) qmem_rd_q <= qmem[q_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      s_rvalid_q <= 1'b0;
    end else begin
      if (s_re) s_rvalid_q <= valid_q[s_raddr];
      if (s_we) valid_q[s_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        heads_q[l] <= HEAD_W'(NUM_SLOTS);
        tails_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (pop_en && lvl_q == LVL_W'(l)) begin
          if (heads_q[l][SLOT_W-1:0] == tails_q[l]) heads_q[l] <= HEAD_W'(NUM_SLOTS);
          else heads_q[l] <= {1'b0, heads_q[l][SLOT_W-1:0] + SLOT_W'(1)};
        end
        if (q_we && push_lvl == LVL_W'(l)) begin
          if (heads_q[l][SLOT_W]) begin
            heads_q[l] <= '0;
            tails_q[l] <= '0;
          end else begin
            tails_q[l] <= tails_q[l] + SLOT_W'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TS_RESET;
      al_q <= AL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_idx_e'(cfg_index_i) == CFG_TIME_SLICES) ts_q <= cfg_data_i;
      else al_q <= cfg_data_i[AL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_valid_q <= 1'b0;
      ctx_q       <= HC_AGE;
      lvl_q       <= '0;
      cnt_q       <= '0;
      res_st_q    <= RS_OK;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_st_q <= RS_OK;
            cnt_q    <= '0;
          end
        end
        S_READ: begin
          if (op_q == OP_PICK) begin
            if (run_valid_q) res_st_q <= RS_BAD;
            lvl_q <= '0;
            ctx_q <= HC_PICK;
          end else if (op_q == OP_YIELD || op_q == OP_SLEEP || op_q == OP_EXIT) begin
            if (!run_valid_q) res_st_q <= RS_BAD;
          end
        end
        S_EXEC: begin
          if (fail_bad) res_st_q <= RS_BAD;
          else if ((op_q == OP_ADMIT || op_q == OP_WAKE) && !push_ok) res_st_q <= RS_FULL;
          if (op_q == OP_SLEEP || op_q == OP_EXIT) run_valid_q <= 1'b0;
          lvl_q <= '0;
          ctx_q <= HC_YIELD;
        end
        S_TICK: begin
          cnt_q <= cnt_q + HEAD_W'(1);
          lvl_q <= LVL_W'(1);
          ctx_q <= HC_AGE;
        end
        S_HQ: begin
          if (q_empty && !adv_last) lvl_q <= lvl_q + LVL_W'(1);
          if (q_empty && adv_last && ctx_q == HC_PICK) res_st_q <= RS_NONE;
        end
        S_HE: begin
          case (ctx_q)
            HC_AGE: begin
              if (age_hit) begin
                if (!push_ok) res_st_q <= RS_FULL;
              end else if (!adv_last) begin
                lvl_q <= lvl_q + LVL_W'(1);
              end
            end
            HC_PICK: begin
              if (hd_ready) begin
                run_valid_q <= 1'b1;
              end else if (adv_last) begin
                res_st_q <= RS_NONE;
              end else begin
                lvl_q <= lvl_q + LVL_W'(1);
              end
            end
            HC_YIELD: begin
              if (!hd_ready && !adv_last) lvl_q <= lvl_q + LVL_W'(1);
            end
            default: ;
          endcase
        end
        S_SWITCH: begin
          run_valid_q <= 1'b0;
          if (!push_ok) res_st_q <= RS_FULL;
        end
        default: ;
      endcase
    end
  end

  // payload registers of the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q       <= op_e'(op_i);
          slot_q     <= slot_i;
          res_sw_q   <= 1'b0;
          res_lvl_q  <= '0;
          res_slot_q <= '0;
        end
      end
      S_READ: begin
        cur_s_q <= slot_q;
        if (op_q == OP_YIELD || op_q == OP_SLEEP || op_q == OP_EXIT) begin
          cur_s_q    <= run_slot_q;
          res_slot_q <= run_slot_q;
        end else if (op_q != OP_PICK && op_q != OP_TICK) begin
          res_slot_q <= slot_q;
        end
      end
      S_EXEC: begin
        cur_row_q <= row_rd;
        res_lvl_q <= (op_q == OP_ADMIT) ? '0 :
                     (op_q == OP_YIELD && slice_out) ? yield_lvl : row_rd.lvl;
        if (op_q == OP_YIELD && slice_out) res_sw_q <= 1'b1;
      end
      S_HS: cur_s_q <= qmem_rd_q;
      S_HE: begin
        if (ctx_q == HC_PICK && hd_ready) begin
          run_slot_q <= cur_s_q;
          res_slot_q <= cur_s_q;
          res_lvl_q  <= row_rd.lvl;
        end
        if (ctx_q == HC_YIELD && hd_ready) res_sw_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o <= res_st_q;
      if (res_st_q == RS_BAD || res_st_q == RS_NONE) begin
        chosen_slot_o  <= '0;
        switched_o     <= 1'b0;
        level_o        <= '0;
      end else begin
        chosen_slot_o  <= res_slot_q;
        switched_o     <= res_sw_q;
        level_o        <= res_lvl_q;
      end
      if (op_q == OP_QUERY && res_st_q == RS_OK) begin
        run_count_o    <= cur_row_q.runs;
        run_time_o     <= cur_row_q.ticks;
        level0_ticks_o <= cur_row_q.plt[0];
        level1_ticks_o <= cur_row_q.plt[1];
        level2_ticks_o <= cur_row_q.plt[2];
        level3_ticks_o <= cur_row_q.plt[3];
        level4_ticks_o <= cur_row_q.plt[4];
      end else begin
        run_count_o    <= '0;
        run_time_o     <= '0;
        level0_ticks_o <= '0;
        level1_ticks_o <= '0;
        level2_ticks_o <= '0;
        level3_ticks_o <= '0;
        level4_ticks_o <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- assertions
`include "mlfq_scheduler_top_assert.svh"

  `MLFQ_ASSERT(a_idle_no_write, (state_q == S_IDLE) |-> (!s_we && !q_we), "memory write while idle")
  `MLFQ_ASSERT(a_push_pop_apart, (pop_en && q_we) |-> (push_lvl != lvl_q), "push and pop on one queue")
  `MLFQ_ASSERT(a_accept_busy, in_acc |=> (state_q != S_IDLE), "sequencer did not start")
  `MLFQ_ASSERT(a_sweep_bound, (state_q == S_TICK) |-> (cnt_q <= HEAD_W'(NUM_SLOTS)), "sweep overrun")

endmodule
